@@ rtl/bbr_pkg.sv @@
// Shared types, constants and helpers of the 3x3 RGB box blur.
package bbr_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam int RECIP_SHIFT = 16;

   typedef logic [23:0] pix_type;   // {blue, green, red}

   // One classified item handed from the front to the back.
   typedef struct packed {
      logic             is_drain;
      pix_type          pix;
      logic [ROW_W-1:0] row;        // row of the results
      logic [COL_W-1:0] col;        // input column, or drain column
      logic             emit_left;  // pixel: give column col-1
      logic             emit_right; // pixel: give column col (row end)
      logic             top_ok;     // top window row lies inside the frame
      logic             left_ok;    // left window column lies inside the frame
      logic             right_ok;   // drain: right column lies inside the frame
      logic             done;       // drain: last pixel of the frame
   } cmd_type;

   // Reciprocal of 2*n scaled by 2^16, rounded up; exact for sums up to 9*255.
   function automatic logic [16:0] recip(input logic [3:0] n);
      logic [16:0] r;
      unique case (n)
         4'd1:    r = 17'd32768;
         4'd2:    r = 17'd16384;
         4'd3:    r = 17'd10923;
         4'd4:    r = 17'd8192;
         4'd6:    r = 17'd5462;
         4'd9:    r = 17'd3641;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/box_blur_3x3_rgb.sv @@
// Top level of the 3x3 RGB box blur: front, command queue and back.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    op, in_red, in_green, in_blue
//   rsp_      out         rsp_valid/rsp_ready    out_red..blue, row, column, flags
//   csr_      in          csr_valid/csr_ready    csr_index, csr_wdata
//
// A pixel item passes read and update, then per result sum, multiply and output,
// which waits for rsp_ready; a drain item reads three columns, then the same. The
// single read port of each line store and the averager's sum/multiply steps set it.
// The front takes items into a four-entry queue while the back works or stalls.
// Reset is synchronous; line stores need no clearing, unused entries are masked.
// Register writes are taken at once; width and height writes restart the frame position.
module box_blur_3x3_rgb import bbr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic [7:0]            req_in_red,
   input  logic [7:0]            req_in_green,
   input  logic [7:0]            req_in_blue,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_red,
   output logic [7:0]            rsp_out_green,
   output logic [7:0]            rsp_out_blue,
   output logic [ROW_W-1:0]      rsp_out_row,
   output logic [COL_W-1:0]      rsp_out_column,
   output logic                  rsp_last_in_run,
   output logic                  rsp_frame_done,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic    q_push, q_pop, q_full, q_empty;
   cmd_type q_entry, q_head;

   // Classify transfers and track the frame position.
   bbr_front u_front (
      .clock, .reset,
      .req_valid, .req_ready, .req_op, .req_in_red, .req_in_green, .req_in_blue,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .q_push, .q_entry, .q_full
   );

   // Hold commands so that front and back stall independently.
   bbr_queue u_queue (
      .clock, .reset,
      .push(q_push), .push_data(q_entry), .pop(q_pop),
      .head(q_head), .full(q_full), .empty(q_empty)
   );

   // Update line stores and window, average, drive the result transfer.
   bbr_back u_back (
      .clock, .reset,
      .q_head, .q_empty, .q_pop,
      .rsp_valid, .rsp_ready, .rsp_out_red, .rsp_out_green, .rsp_out_blue,
      .rsp_out_row, .rsp_out_column, .rsp_last_in_run, .rsp_frame_done
   );

endmodule

@@ rtl/bbr_queue.sv @@
// Short command queue between the front and the back of the blur.
module bbr_queue import bbr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;

   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

@@ rtl/bbr_front.sv @@
// Front of the blur: accepts items and registers, tracks position, classifies items.
module bbr_front import bbr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic [7:0]            req_in_red,
   input  logic [7:0]            req_in_green,
   input  logic [7:0]            req_in_blue,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  q_push,
   output cmd_type               q_entry,
   input  logic                  q_full
);

   logic [COL_W-1:0] width_m1_ff, width_m1_in;
   logic [ROW_W-1:0] height_m1_ff, height_m1_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] dcol_ff, dcol_in;
   logic             draining_ff, draining_in;
   logic             accept, is_drain, last_col, last_row, drain_last;
   logic [CFG_WIDTH_W-1:0]  wr_w;
   logic [CFG_HEIGHT_W-1:0] wr_h;

   assign req_ready = !q_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign is_drain  = (req_op == OP_DRAIN);
   assign last_col  = (col_ff == width_m1_ff);
   assign last_row  = (row_ff == height_m1_ff);
   assign drain_last = (dcol_ff == width_m1_ff);
   assign wr_w = csr_wdata[CFG_WIDTH_W-1:0];
   assign wr_h = csr_wdata[CFG_HEIGHT_W-1:0];

   always_comb begin
      q_push  = 1'b0;
      q_entry = '0;
      if (is_drain) begin
         q_push           = accept && draining_ff;
         q_entry.is_drain = 1'b1;
         q_entry.row      = height_m1_ff;
         q_entry.col      = dcol_ff;
         q_entry.top_ok   = (height_m1_ff != '0);
         q_entry.left_ok  = (dcol_ff != '0);
         q_entry.right_ok = !drain_last;
         q_entry.done     = drain_last;
      end else begin
         q_push             = accept && !draining_ff;
         q_entry.pix        = {req_in_blue, req_in_green, req_in_red};
         q_entry.row        = row_ff - 1'b1;
         q_entry.col        = col_ff;
         q_entry.emit_left  = (row_ff != '0) && (col_ff != '0);
         q_entry.emit_right = (row_ff != '0) && last_col;
         q_entry.top_ok     = (row_ff > ROW_W'(1));
         q_entry.left_ok    = (col_ff > COL_W'(1));
      end
   end

   always_comb begin
      width_m1_in  = width_m1_ff;
      height_m1_in = height_m1_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      dcol_in      = dcol_ff;
      draining_in  = draining_ff;
      if (csr_valid && csr_ready &&
          (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT)) begin
         // A register write restarts the frame.
         if (csr_index == CSR_IMAGE_WIDTH) begin
            if (wr_w == '0) width_m1_in = '0;
            else if (wr_w > CFG_WIDTH_W'(MAX_WIDTH)) width_m1_in = COL_W'(MAX_WIDTH - 1);
            else width_m1_in = COL_W'(wr_w - 1'b1);
         end else begin
            if (wr_h == '0) height_m1_in = '0;
            else if (wr_h > CFG_HEIGHT_W'(MAX_HEIGHT)) height_m1_in = ROW_W'(MAX_HEIGHT - 1);
            else height_m1_in = ROW_W'(wr_h - 1'b1);
         end
         row_in      = '0;
         col_in      = '0;
         dcol_in     = '0;
         draining_in = 1'b0;
      end else if (q_push && !is_drain) begin
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in      = '0;
               draining_in = 1'b1;
               dcol_in     = '0;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end else if (q_push && is_drain) begin
         if (drain_last) begin
            draining_in = 1'b0;
            dcol_in     = '0;
         end else begin
            dcol_in = dcol_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_m1_ff  <= COL_W'(MAX_WIDTH - 1);
         height_m1_ff <= ROW_W'(767);
         row_ff       <= '0;
         col_ff       <= '0;
         dcol_ff      <= '0;
         draining_ff  <= 1'b0;
      end else begin
         width_m1_ff  <= width_m1_in;
         height_m1_ff <= height_m1_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         dcol_ff      <= dcol_in;
         draining_ff  <= draining_in;
      end
   end

endmodule

@@ rtl/bbr_back.sv @@
// Back of the blur: line stores, 3x3 window, averaging and the result register.
module bbr_back import bbr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          q_head,
   input  logic             q_empty,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_red,
   output logic [7:0]       rsp_out_green,
   output logic [7:0]       rsp_out_blue,
   output logic [ROW_W-1:0] rsp_out_row,
   output logic [COL_W-1:0] rsp_out_column,
   output logic             rsp_last_in_run,
   output logic             rsp_frame_done
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_UPD, ST_DRD, ST_SUM, ST_MUL, ST_OUT
   } state_type;

   state_type        state_ff;
   cmd_type          cmd_ff;
   pix_type          up_mem  [MAX_WIDTH];
   pix_type          mid_mem [MAX_WIDTH];
   pix_type          up_rd_ff, mid_rd_ff;
   pix_type          window_ff [9];
   logic [8:0]       mask_ff;
   logic [1:0]       tap_ff;
   logic             second_ff;
   logic [11:0]      sum_ff [3];
   logic [3:0]       n_ff;
   logic [7:0]       q_ff [3];
   logic             valid_ff;
   logic [COL_W-1:0] res_col_ff;
   logic             res_last_ff;
   logic             rd_en, wr_en;
   logic [COL_W-1:0] rd_addr;
   logic [8:0]       mask_left, mask_right, mask_drain;
   logic [11:0]      sum_in [3];
   logic [12:0]      x_in [3];
   logic [29:0]      prod_in [3];

   assign q_pop = (state_ff == ST_IDLE) && !q_empty;

   // Mask bits are row*3 + column of the window.
   assign mask_left  = {3'b111, 3'b111, {2'b11, cmd_ff.left_ok} & {3{cmd_ff.top_ok}}}
                       & {3'b110 | {2'b00, cmd_ff.left_ok}, 3'b110 | {2'b00, cmd_ff.left_ok},
                          3'b111};
   assign mask_right = {1'b1, cmd_ff.col != '0, 1'b0,
                        1'b1, cmd_ff.col != '0, 1'b0,
                        cmd_ff.top_ok, cmd_ff.top_ok && (cmd_ff.col != '0), 1'b0};
   assign mask_drain = {3'b000,
                        cmd_ff.right_ok, 1'b1, cmd_ff.left_ok,
                        cmd_ff.right_ok && cmd_ff.top_ok, cmd_ff.top_ok,
                        cmd_ff.left_ok && cmd_ff.top_ok};

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = cmd_ff.col;
      wr_en   = 1'b0;
      if (state_ff == ST_READ) begin
         rd_en = 1'b1;
      end else if (state_ff == ST_UPD) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_DRD && tap_ff != 2'd3) begin
         rd_en   = 1'b1;
         rd_addr = cmd_ff.col + COL_W'(tap_ff) - 1'b1;
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_in[ch] = '0;
         for (int i = 0; i < 9; i++) begin
            if (mask_ff[i]) sum_in[ch] = sum_in[ch] + 12'(window_ff[i][8*ch +: 8]);
         end
         x_in[ch]    = {sum_ff[ch], 1'b0} + 13'(n_ff);
         prod_in[ch] = 30'(x_in[ch]) * 30'(recip(n_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         up_rd_ff  <= up_mem[rd_addr];
         mid_rd_ff <= mid_mem[rd_addr];
      end
      if (wr_en) begin
         up_mem[cmd_ff.col]  <= mid_rd_ff;
         mid_mem[cmd_ff.col] <= cmd_ff.pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
         tap_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  cmd_ff   <= q_head;
                  tap_ff   <= '0;
                  state_ff <= q_head.is_drain ? ST_DRD : ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               // Shift the window left, load the new column.
               for (int r = 0; r < 3; r++) begin
                  window_ff[3*r]     <= window_ff[3*r + 1];
                  window_ff[3*r + 1] <= window_ff[3*r + 2];
               end
               window_ff[2] <= up_rd_ff;
               window_ff[5] <= mid_rd_ff;
               window_ff[8] <= cmd_ff.pix;
               if (cmd_ff.emit_left) begin
                  mask_ff     <= mask_left;
                  second_ff   <= cmd_ff.emit_right;
                  res_col_ff  <= cmd_ff.col - 1'b1;
                  res_last_ff <= !cmd_ff.emit_right;
                  state_ff    <= ST_SUM;
               end else if (cmd_ff.emit_right) begin
                  mask_ff     <= mask_right;
                  second_ff   <= 1'b0;
                  res_col_ff  <= cmd_ff.col;
                  res_last_ff <= 1'b1;
                  state_ff    <= ST_SUM;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DRD: begin
               if (tap_ff != 2'd0) begin
                  window_ff[4'(tap_ff) - 4'd1] <= up_rd_ff;
                  window_ff[4'(tap_ff) + 4'd2] <= mid_rd_ff;
               end
               tap_ff <= tap_ff + 2'd1;
               if (tap_ff == 2'd3) begin
                  mask_ff     <= mask_drain;
                  second_ff   <= 1'b0;
                  res_col_ff  <= cmd_ff.col;
                  res_last_ff <= 1'b1;
                  state_ff    <= ST_SUM;
               end
            end
            ST_SUM: begin
               for (int ch = 0; ch < 3; ch++) sum_ff[ch] <= sum_in[ch];
               n_ff     <= 4'($countones(mask_ff));
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               for (int ch = 0; ch < 3; ch++) begin
                  q_ff[ch] <= prod_in[ch][RECIP_SHIFT +: 8];
               end
               valid_ff <= 1'b1;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_ready) begin
                  valid_ff <= 1'b0;
                  if (second_ff) begin
                     mask_ff     <= mask_right;
                     second_ff   <= 1'b0;
                     res_col_ff  <= cmd_ff.col;
                     res_last_ff <= 1'b1;
                     state_ff    <= ST_SUM;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_red     = q_ff[0];
   assign rsp_out_green   = q_ff[1];
   assign rsp_out_blue    = q_ff[2];
   assign rsp_out_row     = cmd_ff.row;
   assign rsp_out_column  = res_col_ff;
   assign rsp_last_in_run = res_last_ff;
   assign rsp_frame_done  = cmd_ff.done && res_last_ff;

`ifndef NO_ASSERTIONS
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_frame_done |-> rsp_last_in_run)
      else $error("frame_done without last_in_run");
   a_count_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> (n_ff == 4'd1 || n_ff == 4'd2 || n_ff == 4'd3 ||
                              n_ff == 4'd4 || n_ff == 4'd6 || n_ff == 4'd9))
      else $error("neighbour count outside the legal set");
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> sum_ff[0] < {n_ff, 8'd0})
      else $error("sum exceeds count times full scale");
   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> state_ff == ST_OUT)
      else $error("result shown outside the output state");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the 3x3 RGB box blur: directed table, then random frames.
module tb_top;
   import bbr_pkg::*;

   // Result fields of one emitted pixel, as the rsp_ channel carries them.
   typedef struct packed {
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic             last;
      logic             done;
   } blur_result_t;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_t;

   // One line of the directed table: an item or a register write.
   // Where typed is set, the expected result stands in the row itself.
   typedef struct packed {
      row_kind_t                kind;
      logic                     op;
      pix_type                  pix;
      logic [CSR_IDX_W-1:0]     index;
      logic [CSR_DATA_W-1:0]    wdata;
      logic                     typed;
      blur_result_t             want;
   } script_row_t;

   localparam int SETTLE_CYCLES = 80;   // lets a queue of four items pass through the back
   localparam int HOLD_CYCLES   = 400;  // long receiver stall: fills the queue
   localparam int FRAME_CAP     = 160;  // items per random frame at most, stray items apart

   // Register indexes that the block does not use.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_op;
   logic [7:0]            req_in_red;
   logic [7:0]            req_in_green;
   logic [7:0]            req_in_blue;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [7:0]            rsp_out_red;
   logic [7:0]            rsp_out_green;
   logic [7:0]            rsp_out_blue;
   logic [ROW_W-1:0]      rsp_out_row;
   logic [COL_W-1:0]      rsp_out_column;
   logic                  rsp_last_in_run;
   logic                  rsp_frame_done;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   box_blur_3x3_rgb dut (.*);

   // Predictor state: a private copy of line stores, window, position and registers.
   logic [CFG_WIDTH_W-1:0]  blur_width;
   logic [CFG_HEIGHT_W-1:0] blur_height;
   pix_type                 upper_store [MAX_WIDTH];
   pix_type                 middle_store [MAX_WIDTH];
   logic [8:0][23:0]        window;
   int unsigned             at_row;
   int unsigned             at_column;
   int unsigned             drain_at;
   bit                      draining;

   blur_result_t pending_pixels [$];
   int           mismatches;
   int           random_items;
   bit           quiet;        // no idling on either side for this frame
   bit           hold_request; // ask the receiver for one long stall

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit: far beyond the slowest legal run.
   initial begin
      #80_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int unsigned used_width();
      if (blur_width == 0) return 1;
      if (blur_width > MAX_WIDTH) return MAX_WIDTH;
      return blur_width;
   endfunction

   function automatic int unsigned used_height();
      if (blur_height == 0) return 1;
      if (blur_height > MAX_HEIGHT) return MAX_HEIGHT;
      return blur_height;
   endfunction

   // Per-channel mean of the masked cells, rounded half up.
   function automatic pix_type box_mean(input logic [8:0][23:0] cells, input logic [8:0] mask);
      int unsigned sum [3];
      int unsigned count;
      int unsigned q;
      pix_type     mean;
      count = 0;
      mean  = '0;
      for (int ch = 0; ch < 3; ch++) sum[ch] = 0;
      for (int i = 0; i < 9; i++) begin
         if (mask[i]) begin
            count++;
            for (int ch = 0; ch < 3; ch++) sum[ch] += cells[i][8*ch +: 8];
         end
      end
      if (count == 0) return '0;
      for (int ch = 0; ch < 3; ch++) begin
         q = (2 * sum[ch] + count) / (2 * count);
         if (q > 255) q = 255;
         mean[8*ch +: 8] = q[7:0];
      end
      return mean;
   endfunction

   // Cells around window column k that lie inside the frame.
   function automatic logic [8:0] frame_cells(input int unsigned k, input int unsigned r,
                                              input int unsigned c);
      logic [8:0] m;
      m = '0;
      for (int unsigned i = 0; i < 3; i++) begin
         if (i == 0 && r < 2) continue;
         for (int unsigned j = 0; j < 3; j++) begin
            if (j + 1 < k || j > k + 1) continue;
            if (j + c < 2) continue;
            m[i*3 + j] = 1'b1;
         end
      end
      return m;
   endfunction

   function automatic blur_result_t make_result(input pix_type p, input int unsigned r,
                                                input int unsigned c, input logic last,
                                                input logic done);
      blur_result_t res;
      res.red    = p[7:0];
      res.green  = p[15:8];
      res.blue   = p[23:16];
      res.row    = r[ROW_W-1:0];
      res.column = c[COL_W-1:0];
      res.last   = last;
      res.done   = done;
      return res;
   endfunction

   task automatic reset_blur_state();
      blur_width  = CFG_WIDTH_W'(1024);
      blur_height = CFG_HEIGHT_W'(768);
      window      = '0;
      at_row      = 0;
      at_column   = 0;
      drain_at    = 0;
      draining    = 1'b0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         upper_store[i]  = '0;
         middle_store[i] = '0;
      end
   endtask

   task automatic apply_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      if (index == CSR_IMAGE_WIDTH) blur_width = value[CFG_WIDTH_W-1:0];
      else if (index == CSR_IMAGE_HEIGHT) blur_height = value;
      else return;
      at_row    = 0;
      at_column = 0;
      drain_at  = 0;
      draining  = 1'b0;
   endtask

   // Advance the blur state by one item and return the pixels it releases.
   task automatic blur_step(input logic op, input pix_type pix, output blur_result_t out [$]);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      int unsigned d;
      int unsigned col;
      logic [8:0][23:0] cells;
      logic [8:0] mask;
      logic done;
      w = used_width();
      h = used_height();
      out = {};
      if (op == OP_PIXEL) begin
         if (draining) return;
         r = at_row;
         c = at_column;
         for (int i = 0; i < 3; i++) begin
            window[i*3]     = window[i*3 + 1];
            window[i*3 + 1] = window[i*3 + 2];
         end
         window[2] = upper_store[c];
         window[5] = middle_store[c];
         window[8] = pix;
         upper_store[c]  = middle_store[c];
         middle_store[c] = pix;
         if (r >= 1) begin
            if (c >= 1)
               out.push_back(make_result(box_mean(window, frame_cells(1, r, c)),
                                         r - 1, c - 1, 1'b0, 1'b0));
            if (c + 1 >= w)
               out.push_back(make_result(box_mean(window, frame_cells(2, r, c)),
                                         r - 1, c, 1'b0, 1'b0));
            if (out.size() > 0) out[out.size() - 1].last = 1'b1;
         end
         if (c + 1 >= w) begin
            at_column = 0;
            if (r + 1 >= h) begin
               at_row   = 0;
               draining = 1'b1;
               drain_at = 0;
            end else begin
               at_row = r + 1;
            end
         end else begin
            at_column = c + 1;
         end
      end else begin
         if (!draining) return;
         d = (drain_at >= w) ? w - 1 : drain_at;
         cells = '0;
         mask  = '0;
         for (int unsigned j = 0; j < 3; j++) begin
            if (d + j < 1) continue;
            col = d + j - 1;
            if (col >= w) continue;
            cells[j]     = upper_store[col];
            cells[3 + j] = middle_store[col];
            mask[3 + j]  = 1'b1;
            if (h >= 2) mask[j] = 1'b1;
         end
         done = (d + 1 >= w);
         out.push_back(make_result(box_mean(cells, mask), h - 1, d, 1'b1, done));
         if (done) begin
            draining = 1'b0;
            drain_at = 0;
         end else begin
            drain_at = d + 1;
         end
      end
   endtask

   // Offer one item after a random gap; predict at the transfer edge.
   // Entered and left at a falling edge.
   task automatic send_item(input logic op, input pix_type pix, input bit typed,
                            input blur_result_t want);
      int unsigned gap;
      blur_result_t released [$];
      gap = quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_in_red   <= pix[7:0];
      req_in_green <= pix[15:8];
      req_in_blue  <= pix[23:16];
      do @(posedge clock); while (!req_ready);
      blur_step(op, pix, released);
      if (typed) pending_pixels.push_back(want);
      else foreach (released[i]) pending_pixels.push_back(released[i]);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      // Items with no result may still sit in the block's queue.
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write one register once the block is idle.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      apply_register(index, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One frame of random pixels and its drain, with stray items mixed in and
   // now and then cut short; the next register write restarts the frame anyway.
   // Large frames stop at FRAME_CAP items, stray items apart, to keep the run short.
   task automatic run_frame(input logic [CSR_DATA_W-1:0] width_value,
                            input logic [CSR_DATA_W-1:0] height_value);
      int unsigned total;
      int unsigned w;
      int unsigned stop_at;
      logic op;
      write_register(CSR_IMAGE_WIDTH, width_value);
      write_register(CSR_IMAGE_HEIGHT, height_value);
      w     = used_width();
      total = w * used_height();
      quiet = ($urandom_range(0, 3) == 0);
      stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total + w) : total + w;
      if (stop_at > FRAME_CAP) stop_at = FRAME_CAP;
      for (int unsigned k = 0; k < stop_at; k++) begin
         op = (k < total) ? OP_PIXEL : OP_DRAIN;
         if ($urandom_range(0, 19) == 0)
            send_item(~op, pix_type'($urandom), 1'b0, '0);
         send_item(op, pix_type'($urandom), 1'b0, '0);
         random_items++;
         if (random_items == 150) hold_request = 1'b1;
         if (random_items == 300) drain_results();  // sender pause mid-frame
      end
   endtask

   // Receiver: random stall before each transfer, one long hold on request.
   initial begin
      int unsigned stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            stall = quiet ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Compare every transfer with the oldest predicted pixel.
   always @(posedge clock) begin
      blur_result_t seen;
      blur_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_row,
                  rsp_out_column, rsp_last_in_run, rsp_frame_done};
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: got %p", seen);
         end else begin
            want = pending_pixels.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %p got %p", want, seen);
            end
         end
      end
   end

   // Directed table: tiny frames whose results are plain to see, then a
   // predicted 3x2 frame with extreme values and the unused register indexes.
   script_row_t script [];

   function automatic script_row_t item_row(input logic op, input pix_type pix);
      script_row_t s;
      s = '0;
      s.kind = ROW_ITEM;
      s.op   = op;
      s.pix  = pix;
      return s;
   endfunction

   function automatic script_row_t csr_row(input logic [CSR_IDX_W-1:0] index,
                                           input logic [CSR_DATA_W-1:0] value);
      script_row_t s;
      s = '0;
      s.kind  = ROW_CSR;
      s.index = index;
      s.wdata = value;
      return s;
   endfunction

   // Single-pixel frame: the drain returns that pixel unchanged.
   function automatic script_row_t lone_drain(input pix_type pix);
      script_row_t s;
      s = item_row(OP_DRAIN, pix_type'(24'h0));
      s.typed = 1'b1;
      s.want  = '{pix[7:0], pix[15:8], pix[23:16], '0, '0, 1'b1, 1'b1};
      return s;
   endfunction

   initial begin
      mismatches   = 0;
      random_items = 0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op       = OP_PIXEL;
      req_in_red   = '0;
      req_in_green = '0;
      req_in_blue  = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_IMAGE_WIDTH;
      csr_wdata    = '0;
      reset_blur_state();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      script = new[24];
      script[0]  = csr_row(CSR_IMAGE_WIDTH, 13'd1);
      script[1]  = csr_row(CSR_IMAGE_HEIGHT, 13'd1);
      script[2]  = item_row(OP_DRAIN, 24'h0);          // drain with nothing pending
      script[3]  = item_row(OP_PIXEL, 24'hFFFFFF);
      script[4]  = item_row(OP_PIXEL, 24'h000000);     // pixel while draining
      script[5]  = lone_drain(24'hFFFFFF);
      script[6]  = item_row(OP_PIXEL, 24'h01807F);
      script[7]  = lone_drain(24'h01807F);
      script[8]  = csr_row(CSR_IMAGE_WIDTH, 13'd0);    // zero acts as one
      script[9]  = csr_row(CSR_IMAGE_HEIGHT, 13'd0);
      script[10] = item_row(OP_PIXEL, 24'h55AA00);
      script[11] = lone_drain(24'h55AA00);
      script[12] = csr_row(CSR_IMAGE_WIDTH, 13'd3);
      script[13] = csr_row(CSR_IMAGE_HEIGHT, 13'd2);
      script[14] = item_row(OP_PIXEL, 24'hFFFFFF);
      script[15] = item_row(OP_PIXEL, 24'h000000);
      script[16] = item_row(OP_PIXEL, 24'h000001);
      script[17] = item_row(OP_PIXEL, 24'h000000);
      script[18] = item_row(OP_PIXEL, 24'hFFFFFF);
      script[19] = item_row(OP_PIXEL, 24'hFF00FF);
      script[20] = item_row(OP_DRAIN, 24'h0);
      script[21] = item_row(OP_DRAIN, 24'h0);
      script[22] = item_row(OP_DRAIN, 24'h0);
      script[23] = csr_row(CSR_SPARE_A, 13'h1555);     // unused index: ignored

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) write_register(script[i].index, script[i].wdata);
         else send_item(script[i].op, script[i].pix, script[i].typed, script[i].want);
      end
      write_register(CSR_SPARE_B, 13'h0AAA);

      // Random frames: mostly small, plus the size extremes and clamped values.
      for (int phase = 0; random_items < 550; phase++) begin
         case (phase)
            2:       run_frame(13'd2047, 13'd1);     // above the limit acts as 1024
            5:       run_frame(13'd1, 13'd8191);     // above the limit acts as 4096
            8:       run_frame(13'd1024, 13'd2);
            default: run_frame($urandom_range(0, 8), $urandom_range(0, 6));
         endcase
      end
      quiet = 1'b0;
      drain_results();

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
